### hdl/dpcm_pkg.sv
package dpcm_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int COEF_FRAC_DEF = 14;

  localparam int PIX_W      = 8;
  localparam int ERR_W      = 9;
  localparam int RAW_W      = 10;
  localparam int COEF_W     = 16;
  localparam int DIM_W      = 13;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // 9x16 signed product, four of them summed, plus rounding headroom
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int ACC_W      = PROD_W + 3;

  localparam logic signed [COEF_W-1:0] COEF_UL_RST = 16'sd0;
  localparam logic signed [COEF_W-1:0] COEF_U_RST  = 16'sd0;
  localparam logic signed [COEF_W-1:0] COEF_UR_RST = 16'sd0;
  localparam logic signed [COEF_W-1:0] COEF_L_RST  = 16'sd16384;
  localparam logic [DIM_W-1:0]         WIDTH_RST   = 13'd4096;
  localparam logic [DIM_W-1:0]         HEIGHT_RST  = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_UL = 3'd0,
    CFG_COEF_U  = 3'd1,
    CFG_COEF_UR = 3'd2,
    CFG_COEF_L  = 3'd3,
    CFG_WIDTH   = 3'd4,
    CFG_HEIGHT  = 3'd5
  } dpcm_cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] ul;
    logic signed [COEF_W-1:0] u;
    logic signed [COEF_W-1:0] ur;
    logic signed [COEF_W-1:0] l;
  } dpcm_coef_t;

  typedef struct packed {
    logic [PIX_W-1:0] ul;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] ur;
    logic [PIX_W-1:0] l;
  } dpcm_nbr_t;

  // position flags of the pixel held in the reconstruction stage
  typedef struct packed {
    logic col_nz;
    logic row_nz;
    logic ur_in;
    logic frame_end;
  } dpcm_pos_t;

endpackage

### hdl/dpcm_if.sv
interface dpcm_in_if;
  import dpcm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] error_value;

  modport source (output valid, output error_value, input ready);
  modport sink   (input valid, input error_value, output ready);
endinterface

interface dpcm_out_if;
  import dpcm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PIX_W-1:0]        pixel;
  logic signed [RAW_W-1:0] raw_sum;
  logic                    frame_end;

  modport source (output valid, output pixel, output raw_sum, output frame_end, input ready);
  modport sink   (input valid, input pixel, input raw_sum, input frame_end, output ready);
endinterface

### hdl/dpcm_row_mem.sv
module dpcm_row_mem #(
  parameter int DEPTH = dpcm_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [dpcm_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic [dpcm_pkg::PIX_W-1:0] rdata_a,
  output logic [dpcm_pkg::PIX_W-1:0] rdata_b
);
  import dpcm_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first on a clash so a read sees the pixel finishing in the same cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
      rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end
  end

endmodule

### hdl/dpcm_recon.sv
module dpcm_recon #(
  parameter int COEF_FRAC_BITS = dpcm_pkg::COEF_FRAC_DEF
) (
  input  dpcm_pkg::dpcm_nbr_t               nbr,
  input  dpcm_pkg::dpcm_coef_t              coef,
  input  logic signed [dpcm_pkg::ERR_W-1:0] error_value,
  output logic [dpcm_pkg::PIX_W-1:0]        pixel,
  output logic signed [dpcm_pkg::RAW_W-1:0] raw_sum
);
  import dpcm_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [PIX_W:0]    n_ul, n_u, n_ur, n_l;
  logic signed [PROD_W-1:0] p_ul, p_u, p_ur, p_l;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rounded;
  logic [PIX_W-1:0]         pred;

  assign n_ul = {1'b0, nbr.ul};
  assign n_u  = {1'b0, nbr.u};
  assign n_ur = {1'b0, nbr.ur};
  assign n_l  = {1'b0, nbr.l};

  assign p_ul = n_ul * coef.ul;
  assign p_u  = n_u  * coef.u;
  assign p_ur = n_ur * coef.ur;
  assign p_l  = n_l  * coef.l;

  assign acc = ACC_W'(p_ul) + ACC_W'(p_u) + ACC_W'(p_ur) + ACC_W'(p_l);
  assign rounded = (acc + HALF) >>> COEF_FRAC_BITS;

  // a negative sum always saturates to 0
  always_comb begin
    if (acc[ACC_W-1]) begin
      pred = '0;
    end else if (|rounded[ACC_W-1:PIX_W]) begin
      pred = '1;
    end else begin
      pred = rounded[PIX_W-1:0];
    end
  end

  assign raw_sum = RAW_W'(error_value) + $signed({2'b00, pred});

  always_comb begin
    if (raw_sum[RAW_W-1]) begin
      pixel = '0;
    end else if (raw_sum[PIX_W]) begin
      pixel = '1;
    end else begin
      pixel = raw_sum[PIX_W-1:0];
    end
  end

endmodule

### hdl/dpcm_pixel_decoder.sv
// Pipeline: a pixel transferred in is held in the reconstruction stage and is loaded into the
//   result register when that stage fires, which waits while the result register holds an untaken result.
// Throughput: one pixel per cycle unless the output stalls, bounded by the left-neighbour
//   feedback through the multiply-add, rounding and clamp of the reconstruction stage.
// Reset (synchronous, active low): counters, neighbour registers, pipeline valids and
//   configuration registers return to their defaults; the row memory is not cleared.
module dpcm_pixel_decoder #(
  parameter int MAX_WIDTH      = dpcm_pkg::MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = dpcm_pkg::COEF_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dpcm_in_if.sink                         in_chan,
  dpcm_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [dpcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dpcm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);
  localparam logic [EW-1:0] MAX_W_EXT = EW'(MAX_WIDTH);

  dpcm_coef_t       coef_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    width_m1;
  logic [ROW_W-1:0] height_m1;
  logic [EW-1:0]    width_ext;
  logic             row_end, frame_end_nxt;
  logic [CW-1:0]    rd_addr_ur;

  logic                    in_ready;
  logic                    in_xfer;
  logic                    s1_valid_r;
  logic                    s1_fire;
  logic signed [ERR_W-1:0] s1_err_r;
  logic [CW-1:0]           s1_col_r;
  dpcm_pos_t               s1_pos_r;
  dpcm_pos_t               pos_nxt;

  logic [PIX_W-1:0] rd_u, rd_ur;
  logic [PIX_W-1:0] left_r, ul_r;
  dpcm_nbr_t        nbr;

  logic [PIX_W-1:0]        pix;
  logic signed [RAW_W-1:0] raw;

  logic                    out_valid_r;
  logic [PIX_W-1:0]        out_pixel_r;
  logic signed [RAW_W-1:0] out_raw_r;
  logic                    out_fend_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.ul <= COEF_UL_RST;
      coef_r.u  <= COEF_U_RST;
      coef_r.ur <= COEF_UR_RST;
      coef_r.l  <= COEF_L_RST;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_UL: coef_r.ul <= $signed(cfg_data[COEF_W-1:0]);
        CFG_COEF_U:  coef_r.u  <= $signed(cfg_data[COEF_W-1:0]);
        CFG_COEF_UR: coef_r.ur <= $signed(cfg_data[COEF_W-1:0]);
        CFG_COEF_L:  coef_r.l  <= $signed(cfg_data[COEF_W-1:0]);
        CFG_WIDTH:   width_r   <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:  height_r  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero counts as one, width capped at the row memory depth
  assign width_ext = EW'(width_r);

  always_comb begin
    if (width_r == '0) begin
      width_m1 = '0;
    end else if (width_ext > MAX_W_EXT) begin
      width_m1 = COL_LAST;
    end else begin
      width_m1 = CW'(width_ext - EW'(1));
    end
  end

  assign height_m1 = (height_r == '0) ? '0 : height_r - ROW_W'(1);

  // raster position of the next pixel to be transferred in
  assign row_end       = (col_r >= width_m1);
  assign frame_end_nxt = row_end && (row_r >= height_m1);
  assign col_nxt       = row_end ? '0 : col_r + CW'(1);
  assign row_nxt       = frame_end_nxt ? '0 : (row_end ? row_r + ROW_W'(1) : row_r);
  assign rd_addr_ur    = (col_r == COL_LAST) ? '0 : col_r + CW'(1);

  assign pos_nxt.col_nz    = (col_r != '0);
  assign pos_nxt.row_nz    = (row_r != '0);
  assign pos_nxt.ur_in     = !row_end;
  assign pos_nxt.frame_end = frame_end_nxt;

  // handshake: the reconstruction stage doubles as the skid stage
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_xfer  = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_err_r <= in_chan.error_value;
      s1_col_r <= col_r;
      s1_pos_r <= pos_nxt;
    end
  end

  dpcm_row_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_row_mem (
    .clk     (clk),
    .we      (s1_fire),
    .waddr   (s1_col_r),
    .wdata   (pix),
    .re      (in_xfer),
    .raddr_a (col_r),
    .raddr_b (rd_addr_ur),
    .rdata_a (rd_u),
    .rdata_b (rd_ur)
  );

  // neighbours outside the image count as zero
  assign nbr.u  = s1_pos_r.row_nz ? rd_u : '0;
  assign nbr.ur = (s1_pos_r.row_nz && s1_pos_r.ur_in) ? rd_ur : '0;
  assign nbr.ul = (s1_pos_r.row_nz && s1_pos_r.col_nz) ? ul_r : '0;
  assign nbr.l  = s1_pos_r.col_nz ? left_r : '0;

  dpcm_recon #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_recon (
    .nbr         (nbr),
    .coef        (coef_r),
    .error_value (s1_err_r),
    .pixel       (pix),
    .raw_sum     (raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (s1_fire) begin
      left_r <= pix;
      ul_r   <= nbr.u;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pixel_r <= pix;
      out_raw_r   <= raw;
      out_fend_r  <= s1_pos_r.frame_end;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pixel     = out_pixel_r;
  assign out_chan.raw_sum   = out_raw_r;
  assign out_chan.frame_end = out_fend_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_err_r) && $stable(s1_col_r))
    else $error("reconstruction stage lost its pixel while stalled");

  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("finished pixel did not reach the result register");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && frame_end_nxt |=> (col_r == '0) && (row_r == '0))
    else $error("raster position not cleared after the last pixel of a frame");

endmodule
